[hdl/nq_pkg.sv]
package nq_pkg;

  // fixed field widths of the request and result words
  localparam int SIZE_W  = 5;
  localparam int FIELD_W = 4;

  // search sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_BACK = 6'b000100,
    S_LOAD = 6'b001000,
    S_PUSH = 6'b010000,
    S_FAIL = 6'b100000
  } nq_state_t;

endpackage

[hdl/nq_ram.sv]
module nq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/n_queens_backtrack_solver.sv]
// N-queens solver. A word on the input carries a board size n; the block
// searches depth first, column by column with rows tried in ascending order,
// for the first placement of n non-attacking queens, then returns n words
// (column, queen_row, found=1), with last set on column n-1. For n = 2 or 3,
// for n = 0 and for n above MAX_N it returns a single word with found=0 and
// last=1. The block takes one request at a time and is not ready while it
// searches. Timing: one candidate square is tested per cycle by the single
// occupancy checker in S_SCAN, each step back waits for a read of the
// placement RAM, whose read port is registered, and each column is read
// out through S_LOAD and then S_PUSH, which waits while the output is held.
// The search time is data dependent. The block needs no clearing pass after
// reset.
module n_queens_backtrack_solver
  import nq_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SIZE_W-1:0]  in_board_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_column,
  output logic [FIELD_W-1:0] out_queen_row,
  output logic               out_found,
  output logic               out_last
);

  localparam int IDX_W  = $clog2(MAX_N);
  localparam int CNT_W  = $clog2(MAX_N + 1);
  localparam int DIAG_N = 2 * MAX_N - 1;
  localparam int DI_W   = $clog2(DIAG_N);

  nq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [MAX_N-1:0]  rows_r, rows_nxt;
  logic [DIAG_N-1:0] rise_r, rise_nxt;
  logic [DIAG_N-1:0] fall_r, fall_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_column_r, out_column_nxt;
  logic [FIELD_W-1:0] out_queen_row_r, out_queen_row_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_last_r, out_last_nxt;

  // placement store
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  // shared occupancy unit
  logic [IDX_W-1:0] chk_row;
  logic [IDX_W-1:0] chk_col;
  logic [DI_W-1:0]  rise_idx;
  logic [DI_W-1:0]  fall_idx;
  logic             sq_free;
  logic             out_free;
  logic             size_ok;

  nq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_N)
  ) u_place (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // square under test: the scanned row, or the stored row when stepping back
  assign chk_row  = (state_r == S_BACK) ? ram_rdata : row_r[IDX_W-1:0];
  assign chk_col  = col_r[IDX_W-1:0];
  assign rise_idx = DI_W'(chk_row) + DI_W'(chk_col);
  assign fall_idx = DI_W'(chk_row) + DI_W'(MAX_N - 1) - DI_W'(chk_col);
  assign sq_free  = !rows_r[chk_row] && !rise_r[rise_idx] && !fall_r[fall_idx];

  assign out_free = !out_valid_r || out_ready;
  assign size_ok  = (in_board_size != '0) &&
                    ({1'b0, in_board_size} <= (SIZE_W + 1)'(MAX_N));

  assign ram_we    = (state_r == S_SCAN) && (col_r < n_r) && (row_r < n_r) && sq_free;
  assign ram_waddr = col_r[IDX_W-1:0];
  assign ram_wdata = row_r[IDX_W-1:0];
  // step back reads the previous column; readout reads the current one
  assign ram_raddr = (state_r == S_SCAN) ? IDX_W'(col_r - 1'b1) : col_r[IDX_W-1:0];

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    n_nxt             = n_r;
    col_nxt           = col_r;
    row_nxt           = row_r;
    rows_nxt          = rows_r;
    rise_nxt          = rise_r;
    fall_nxt          = fall_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_column_nxt    = out_column_r;
    out_queen_row_nxt = out_queen_row_r;
    out_found_nxt     = out_found_r;
    out_last_nxt      = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = CNT_W'(in_board_size);
          col_nxt   = '0;
          row_nxt   = '0;
          rows_nxt  = '0;
          rise_nxt  = '0;
          fall_nxt  = '0;
          state_nxt = size_ok ? S_SCAN : S_FAIL;
        end
      end
      S_SCAN: begin
        if (col_r >= n_r) begin
          // board full: read it out from column 0
          col_nxt   = '0;
          state_nxt = S_LOAD;
        end else if (row_r < n_r) begin
          if (sq_free) begin
            rows_nxt[chk_row]  = 1'b1;
            rise_nxt[rise_idx] = 1'b1;
            fall_nxt[fall_idx] = 1'b1;
            col_nxt            = col_r + 1'b1;
            row_nxt            = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else if (col_r == '0) begin
          state_nxt = S_FAIL;
        end else begin
          col_nxt   = col_r - 1'b1;
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        // lift the queen of the previous column and try its next row
        rows_nxt[chk_row]  = 1'b0;
        rise_nxt[rise_idx] = 1'b0;
        fall_nxt[fall_idx] = 1'b0;
        row_nxt            = CNT_W'(ram_rdata) + 1'b1;
        state_nxt          = S_SCAN;
      end
      S_LOAD: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_column_nxt    = FIELD_W'(col_r);
          out_queen_row_nxt = FIELD_W'(ram_rdata);
          out_found_nxt     = 1'b1;
          out_last_nxt      = (col_r == n_r - 1'b1);
          if (col_r == n_r - 1'b1) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_FAIL: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_column_nxt    = '0;
          out_queen_row_nxt = '0;
          out_found_nxt     = 1'b0;
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // search and result registers
  always_ff @(posedge clk) begin
    n_r             <= n_nxt;
    col_r           <= col_nxt;
    row_r           <= row_nxt;
    rows_r          <= rows_nxt;
    rise_r          <= rise_nxt;
    fall_r          <= fall_nxt;
    out_column_r    <= out_column_nxt;
    out_queen_row_r <= out_queen_row_nxt;
    out_found_r     <= out_found_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_column    = out_column_r;
  assign out_queen_row = out_queen_row_r;
  assign out_found     = out_found_r;
  assign out_last      = out_last_r;

endmodule
